### hdl/imhq_pkg.sv
// Package for the indexed min-heap queue core.
// Holds operation and status codes and the sequencer state type; no dependencies.
package imhq_pkg;

    localparam int ID_WIDTH = 10;
    localparam int ID_COUNT = 1024;
    localparam int CAP_WIDTH = 11;
    localparam int STATUS_WIDTH = 3;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_EXTRACT = 2'd1;
    localparam logic [1:0] KIND_DECREASE = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_ABSENT = 3'd3;
    localparam logic [2:0] ST_PRESENT = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POS_RD,
        S_ROOT_RD,
        S_LAST_RD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

endpackage

### hdl/indexed_min_heap_queue_core.sv
// Top level of the indexed min-heap queue core.
// Uses imhq_pkg; the heap slots, position table and presence bits are local memories.
//
//  channel   | signals                         | word
//  s_axis    | tvalid tready tdata tuser       | tdata: node_id[9:0] key[41:10]; tuser: kind
//  m_axis    | tvalid tready tdata             | status, out_node_id, out_key, count
//  cfg       | cfg_we cfg_wdata                | capacity
//
// The slot memory has one read port and is walked one heap level at a time.
// After reset the presence bits are cleared by a sweep over all ID_COUNT entries,
// during which no word is accepted. A finished word waits in the output register;
// the next word is accepted only once it has been taken.
module indexed_min_heap_queue_core #(
    parameter int MAX_ENTRIES = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [((imhq_pkg::ID_WIDTH + KEY_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata, // node_id, key
    input  logic [1:0] s_axis_tuser, // kind
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // status, out_node_id, out_key, count
    output logic [((imhq_pkg::STATUS_WIDTH + imhq_pkg::ID_WIDTH + KEY_WIDTH
                    + imhq_pkg::CAP_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic cfg_we,
    input  logic [imhq_pkg::CAP_WIDTH-1:0] cfg_wdata
);
    import imhq_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = AW + 1;
    localparam int OUTW = STATUS_WIDTH + ID_WIDTH + KEY_WIDTH + CAP_WIDTH;
    localparam int OUTP = ((OUTW + 7) / 8) * 8;
    localparam int LIMW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;

    typedef logic signed [KEY_WIDTH-1:0] key_t;

    logic [ID_WIDTH+KEY_WIDTH-1:0] slot_mem [MAX_ENTRIES];
    logic [AW-1:0] pos_mem [ID_COUNT];
    logic present_mem [ID_COUNT];

    state_t state_reg, state_next;
    logic [CAP_WIDTH-1:0] capacity_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [ID_WIDTH-1:0] clr_reg;
    logic clearing_reg;
    logic [1:0] kind_reg;
    logic [ID_WIDTH-1:0] id_reg;
    key_t key_reg;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] cand_reg, cand_next;
    logic [ID_WIDTH-1:0] cur_id_reg, cur_id_next;
    key_t cur_key_reg, cur_key_next;
    logic [ID_WIDTH-1:0] best_id_reg, best_id_next;
    key_t best_key_reg, best_key_next;
    logic rd_right_reg, rd_right_next;
    logic [OUTW-1:0] out_reg;
    logic out_valid_reg;
    logic [STATUS_WIDTH-1:0] status_next;
    logic [ID_WIDTH-1:0] rid_reg, rid_next;
    key_t rkey_reg, rkey_next;

    logic present_q;
    logic [AW-1:0] pos_q;
    logic [ID_WIDTH+KEY_WIDTH-1:0] slot_q;
    logic [ID_WIDTH-1:0] slot_q_id;
    key_t slot_q_key;

    logic slot_re, slot_we, pos_we, pres_we, pres_wval;
    logic [AW-1:0] slot_raddr, slot_waddr, pos_wdata;
    logic [ID_WIDTH+KEY_WIDTH-1:0] slot_wdata;
    logic [ID_WIDTH-1:0] pos_waddr, pres_waddr, id_raddr;
    logic accept, finish;
    logic [LIMW-1:0] limit;
    logic [CW:0] left_idx, right_idx;

    assign slot_q_id = slot_q[ID_WIDTH-1:0];
    assign slot_q_key = slot_q[ID_WIDTH+KEY_WIDTH-1:ID_WIDTH];
    assign s_axis_tready = (state_reg == S_IDLE) && !clearing_reg && !out_valid_reg;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign finish = (state_reg == S_DONE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = OUTP'(out_reg);
    assign limit = (LIMW'(capacity_reg) < LIMW'(MAX_ENTRIES)) ? LIMW'(capacity_reg)
                                                              : LIMW'(MAX_ENTRIES);
    assign left_idx = {1'b0, pos_reg, 1'b1};
    assign right_idx = {1'b0, pos_reg, 1'b0} + (CW+1)'(2);
    assign id_raddr = accept ? s_axis_tdata[ID_WIDTH-1:0] : id_reg;

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        if (slot_re)
            slot_q <= slot_mem[slot_raddr];
        if (pos_we)
            pos_mem[pos_waddr] <= pos_wdata;
        pos_q <= pos_mem[id_raddr];
        if (pres_we)
            present_mem[pres_waddr] <= pres_wval;
        present_q <= present_mem[id_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            capacity_reg <= CAP_WIDTH'(1024);
            count_reg <= '0;
            clr_reg <= '0;
            clearing_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
                capacity_reg <= cfg_wdata;
            if (clearing_reg)
            begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_reg == ID_WIDTH'(ID_COUNT - 1))
                    clearing_reg <= 1'b0;
            end
            if (finish)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_axis_tuser;
            id_reg <= s_axis_tdata[ID_WIDTH-1:0];
            key_reg <= s_axis_tdata[ID_WIDTH+KEY_WIDTH-1:ID_WIDTH];
        end
        pos_reg <= pos_next;
        cand_reg <= cand_next;
        cur_id_reg <= cur_id_next;
        cur_key_reg <= cur_key_next;
        best_id_reg <= best_id_next;
        best_key_reg <= best_key_next;
        rd_right_reg <= rd_right_next;
        rid_reg <= rid_next;
        rkey_reg <= rkey_next;
        if (finish)
            out_reg <= {CAP_WIDTH'(count_reg), rkey_reg, rid_reg, status_next};
    end

    logic [STATUS_WIDTH-1:0] status_reg;
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    function automatic key_t best_next_key(key_t b, key_t q);
        return (b > q) ? q : b;
    endfunction

    function automatic logic [ID_WIDTH-1:0] best_next_id(key_t b, key_t q,
                                                       logic [ID_WIDTH-1:0] bi,
                                                       logic [ID_WIDTH-1:0] qi);
        return (b > q) ? qi : bi;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_POS_RD;
            S_POS_RD:
                case (kind_reg)
                    KIND_INSERT:
                        state_next = (present_q || (LIMW'(count_reg) >= limit)) ? S_DONE
                                                                                 : S_UP_RD;
                    KIND_EXTRACT:
                        state_next = (count_reg == '0) ? S_DONE : S_ROOT_RD;
                    KIND_DECREASE:
                        state_next = present_q ? S_UP_RD : S_DONE;
                    default:
                        state_next = S_DONE;
                endcase
            S_ROOT_RD:
                state_next = S_LAST_RD;
            S_LAST_RD:
                state_next = (count_reg == '0) ? S_DONE : S_DN_RD;
            S_UP_RD:
                state_next = (pos_reg == '0) ? S_DONE : S_UP_CMP;
            S_UP_CMP:
                state_next = (slot_q_key > cur_key_reg) ? S_UP_RD : S_DONE;
            S_DN_RD:
                state_next = (left_idx >= (CW+1)'(count_reg)) ? S_DONE : S_DN_CMP;
            S_DN_CMP:
                if (!rd_right_reg && (right_idx < (CW+1)'(count_reg)))
                    state_next = S_DN_CMP;
                else
                    state_next = (cand_next != pos_reg) ? S_DN_RD : S_DONE;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        slot_re = 1'b0;
        slot_raddr = '0;
        slot_we = 1'b0;
        slot_waddr = pos_reg;
        slot_wdata = {cur_key_reg, cur_id_reg};
        pos_we = 1'b0;
        pos_waddr = cur_id_reg;
        pos_wdata = pos_reg;
        pres_we = clearing_reg;
        pres_waddr = clr_reg;
        pres_wval = 1'b0;
        count_next = count_reg;
        pos_next = pos_reg;
        cand_next = cand_reg;
        cur_id_next = cur_id_reg;
        cur_key_next = cur_key_reg;
        best_id_next = best_id_reg;
        best_key_next = best_key_reg;
        rd_right_next = rd_right_reg;
        rid_next = rid_reg;
        rkey_next = rkey_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                status_next = ST_OK;
                rid_next = '0;
                rkey_next = '0;
            end
            S_POS_RD:
            begin
                cur_id_next = id_reg;
                cur_key_next = key_reg;
                case (kind_reg)
                    KIND_INSERT:
                        if (present_q)
                            status_next = ST_PRESENT;
                        else if (LIMW'(count_reg) >= limit)
                            status_next = ST_FULL;
                        else
                        begin
                            pos_next = AW'(count_reg);
                            count_next = count_reg + 1'b1;
                            pres_we = 1'b1;
                            pres_waddr = id_reg;
                            pres_wval = 1'b1;
                        end
                    KIND_EXTRACT:
                        if (count_reg == '0)
                            status_next = ST_EMPTY;
                        else
                        begin
                            slot_re = 1'b1;
                            slot_raddr = '0;
                        end
                    KIND_DECREASE:
                        if (!present_q)
                            status_next = ST_ABSENT;
                        else
                            pos_next = pos_q;
                    default:
                        status_next = ST_OK;
                endcase
            end
            S_ROOT_RD:
            begin
                rid_next = slot_q_id;
                rkey_next = slot_q_key;
                pres_we = 1'b1;
                pres_waddr = slot_q_id;
                pres_wval = 1'b0;
                slot_re = 1'b1;
                slot_raddr = AW'(count_reg - 1'b1);
                count_next = count_reg - 1'b1;
                pos_next = '0;
            end
            S_LAST_RD:
            begin
                cur_id_next = slot_q_id;
                cur_key_next = slot_q_key;
                if (count_reg != '0)
                begin
                    slot_we = 1'b1;
                    slot_waddr = '0;
                    slot_wdata = slot_q;
                    pos_we = 1'b1;
                    pos_waddr = slot_q_id;
                    pos_wdata = '0;
                end
            end
            S_UP_RD:
            begin
                slot_we = 1'b1;
                pos_we = 1'b1;
                if (pos_reg != '0)
                begin
                    slot_re = 1'b1;
                    slot_raddr = AW'((pos_reg - 1'b1) >> 1);
                    cand_next = slot_raddr;
                end
            end
            S_UP_CMP:
                if (slot_q_key > cur_key_reg)
                begin
                    slot_we = 1'b1;
                    slot_wdata = slot_q;
                    pos_we = 1'b1;
                    pos_waddr = slot_q_id;
                    pos_wdata = pos_reg;
                    pos_next = cand_reg;
                end
            S_DN_RD:
            begin
                slot_we = 1'b1;
                pos_we = 1'b1;
                best_id_next = cur_id_reg;
                best_key_next = cur_key_reg;
                cand_next = pos_reg;
                rd_right_next = 1'b0;
                if (left_idx < (CW+1)'(count_reg))
                begin
                    slot_re = 1'b1;
                    slot_raddr = AW'(left_idx);
                end
            end
            S_DN_CMP:
            begin
                if (best_key_reg > slot_q_key)
                begin
                    best_id_next = slot_q_id;
                    best_key_next = slot_q_key;
                    cand_next = rd_right_reg ? AW'(right_idx) : AW'(left_idx);
                end
                if (!rd_right_reg && right_idx < (CW+1)'(count_reg))
                begin
                    slot_re = 1'b1;
                    slot_raddr = AW'(right_idx);
                    rd_right_next = 1'b1;
                end
                else if (cand_next != pos_reg)
                begin
                    slot_we = 1'b1;
                    slot_wdata = {best_next_key(best_key_reg, slot_q_key),
                                  best_next_id(best_key_reg, slot_q_key,
                                               best_id_reg, slot_q_id)};
                    pos_we = 1'b1;
                    pos_waddr = slot_wdata[ID_WIDTH-1:0];
                    pos_wdata = pos_reg;
                    pos_next = cand_next;
                end
                else
                    pos_next = pos_reg;
            end
            default:
            begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> m_axis_tvalid)
        else $error("finished word not presented");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("word accepted while an operation runs");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above heap size");
`endif

endmodule
